### rtl/core/nxg_pkg.sv
package nxg_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int STACK_DEPTH = 1024;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [CNT_W-1:0]              t_count;
    typedef logic [ADDR_W-1:0]             t_addr;

    typedef enum logic {
        ST_IDLE,
        ST_CMP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic pop;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_ok;
        logic out_free;
    } t_status;

endpackage

### rtl/core/nxg_ram.sv
module nxg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/nxg_datapath.sv
module nxg_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nxg_pkg::t_cmd     i_cmd,
    output nxg_pkg::t_status  o_status,
    input  nxg_pkg::t_value   i_value,
    input  logic              i_new_array,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_has_greater,
    output nxg_pkg::t_value   o_greater_value,
    output logic              o_overflow
);
    import nxg_pkg::*;

    t_count r_count;
    t_count n_count;
    t_value r_key;
    t_value r_top;
    logic   r_sel;
    logic   r_valid;
    logic   r_has;
    t_value r_gv;
    logic   r_ovf;

    t_value cur_top;
    t_value ram_rdata;
    t_addr  ram_raddr;
    logic   ram_we;
    logic   not_empty;
    logic   full;

    // The top of stack sits in r_top, or in the RAM read register straight after a pop.
    assign cur_top   = r_sel ? ram_rdata : r_top;
    assign not_empty = (r_count != '0);
    assign full      = (r_count == CNT_W'(STACK_DEPTH));
    assign ram_raddr = ADDR_W'(r_count - CNT_W'(2));
    assign ram_we    = i_cmd.finish && !full;

    assign o_status.pop_ok   = not_empty && (cur_top <= r_key);
    assign o_status.out_free = !r_valid || i_ready;

    nxg_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[ADDR_W-1:0]),
        .i_wdata(r_key),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_count = r_count;
        if (i_cmd.load_in && i_new_array) begin
            n_count = '0;
        end
        if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
        if (ram_we) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sel   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_sel   <= i_cmd.pop;
            if (i_cmd.finish) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_key <= i_value;
        end
        r_top <= ram_we ? r_key : cur_top;
        if (i_cmd.finish) begin
            r_has <= not_empty;
            r_gv  <= not_empty ? cur_top : '0;
            r_ovf <= full;
        end
    end

    assign o_valid         = r_valid;
    assign o_has_greater   = r_has;
    assign o_greater_value = r_gv;
    assign o_overflow      = r_ovf;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> r_count == CNT_W'($past(r_count) - CNT_W'(1)))
        else $error("pop did not decrement the count");

    a_ovf_has: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_ovf) |-> r_has)
        else $error("overflow reported on an empty stack");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_has) |-> (r_gv == '0))
        else $error("greater value not zero when none exists");

endmodule

### rtl/core/nxg_ctrl.sv
module nxg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  nxg_pkg::t_status i_status,
    output nxg_pkg::t_cmd    o_cmd
);
    import nxg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_status.pop_ok) begin
                    o_cmd.pop = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/next_greater_right_stack.sv
// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_ready   i_value, i_new_array
// result   out        o_valid / i_ready   o_has_greater, o_greater_value, o_overflow
//
// An item passes through an accept step, one pop step per entry it pops off the stack,
// and a final step that pushes it (unless the stack is full) and registers the result.
// Pops run back to back because the stack RAM's registered read of the next entry
// overlaps the following compare.
// Reset clears the stack count and the handshake state; the stack RAM is not cleared.
// A result waiting in the output register does not block acceptance of the next item;
// only the final step of that next item waits until the output register is free.
module next_greater_right_stack (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  nxg_pkg::t_value i_value,
    input  logic            i_new_array,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_has_greater,
    output nxg_pkg::t_value o_greater_value,
    output logic            o_overflow
);
    import nxg_pkg::*;

    // Commands and status between the sequencer and the stack datapath.
    t_cmd    cmd;
    t_status status;

    // The controller walks each item through accept, a pop loop and a final push.
    nxg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_status(status),
        .o_cmd   (cmd)
    );

    // The datapath holds the stack RAM, its count, the cached top entry and the
    // output register.
    nxg_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_value        (i_value),
        .i_new_array    (i_new_array),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_has_greater  (o_has_greater),
        .o_greater_value(o_greater_value),
        .o_overflow     (o_overflow)
    );

endmodule
